FILE: design/omw_pkg.sv
`timescale 1ns / 1ps

package omw_pkg;

    localparam int WHEELS = 4;
    localparam int NSTG   = 10;   // register stages from input to output
    localparam int IDXW   = 3;
    localparam int VW     = 16;   // twist field width
    localparam int OUTW   = 24;
    localparam int CALW   = 12;
    localparam int GEOW   = 16;
    localparam int MW     = 46;   // wheel command after each rounding
    localparam int PW     = MW + CALW + 1;

    typedef enum logic [IDXW-1:0] {
        REG_GEO0 = 3'd0,
        REG_GEO1 = 3'd1,
        REG_GEO2 = 3'd2,
        REG_CAL0 = 3'd3,
        REG_CAL1 = 3'd4,
        REG_CAL2 = 3'd5,
        REG_CAL3 = 3'd6,
        REG_BODY = 3'd7
    } t_reg_idx;

    // calibration lanes, lowest first
    localparam int CAL_OVR = 0;
    localparam int CAL_POS = 1;
    localparam int CAL_NEG = 2;
    localparam int CAL_WST = 3;
    localparam int CAL_EST = 4;

    localparam logic [15:0]     LAT_MIN = 16'd410;
    localparam logic [CALW-1:0] OVR_LO  = 12'd1024;
    localparam logic [CALW-1:0] OVR_HI  = 12'd3072;
    localparam logic [CALW-1:0] SC_LO   = 12'd1638;
    localparam logic [CALW-1:0] SC_HI   = 12'd2458;
    localparam logic [CALW-1:0] ONE_Q11 = 12'd2048;

    localparam logic [63:0] GEO_RST  = 64'd0;
    localparam logic [59:0] CAL_RST  = 60'd576601524159907840;
    localparam logic [63:0] BODY_RST = 64'd268435456;

    typedef struct packed {
        logic [NSTG-1:0] en;    // stage register loads
        logic [NSTG-1:0] vld;   // stage holds a live item
    } t_pipe_ctl;

    function automatic logic [CALW-1:0] clamp_cal(
        input logic [CALW-1:0] f,
        input logic [CALW-1:0] lo,
        input logic [CALW-1:0] hi
    );
        logic [CALW-1:0] r;
        if (f < lo) begin
            r = lo;
        end else if (f > hi) begin
            r = hi;
        end else begin
            r = f;
        end
        return r;
    endfunction

    // round to nearest, ties up, dropping 11 fraction bits
    function automatic logic signed [MW-1:0] rnd11(input logic signed [PW-1:0] x);
        logic signed [PW:0] s;
        s = $signed({x[PW-1], x}) + $signed((PW+1)'(1024));
        return s[MW+10:11];
    endfunction

endpackage

FILE: design/omw_pipe_ctrl.sv
`timescale 1ns / 1ps

module omw_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output omw_pkg::t_pipe_ctl   o_ctl
);

    logic [omw_pkg::NSTG-1:0] r_vld;
    logic [omw_pkg::NSTG-1:0] n_vld;
    logic [omw_pkg::NSTG-1:0] rdy;

    // a stage moves when empty or when the one after it moves
    always_comb begin
        rdy[omw_pkg::NSTG-1] = ~r_vld[omw_pkg::NSTG-1] | i_out_ready;
        for (int s = omw_pkg::NSTG - 2; s >= 0; s--) begin
            rdy[s] = ~r_vld[s] | rdy[s+1];
        end
        n_vld = r_vld;
        for (int s = 0; s < omw_pkg::NSTG; s++) begin
            if (rdy[s]) begin
                n_vld[s] = (s == 0) ? i_in_valid : r_vld[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[omw_pkg::NSTG-1];
    assign o_ctl.en    = rdy;
    assign o_ctl.vld   = r_vld;

endmodule

FILE: design/omw_blend_div.sv
`timescale 1ns / 1ps

// Blend scale 2048 + (f-2048)*diff/ax, rounded and clamped, 2048 on bypass; restoring divide, 3 bits a stage.
// Result registered at stage 7.
module omw_blend_div (
    input  logic                          i_clk,
    input  omw_pkg::t_pipe_ctl            i_ctl,
    input  logic [omw_pkg::CALW-1:0]      i_factor,
    input  logic [16:0]                   i_diff,
    input  logic [16:0]                   i_ax,
    input  logic                          i_byp,
    output logic [omw_pkg::CALW-1:0]      o_blend
);

    localparam int QW   = 12;
    localparam int BPS  = 3;
    localparam int NDS  = QW / BPS;
    localparam int REMW = 18;

    logic signed [30:0] r1_num;
    logic [16:0]        r1_ax;
    logic               r1_byp;

    logic [REMW-1:0]    r_rem [0:NDS];
    logic [QW-1:0]      r_low [0:NDS];
    logic [QW-1:0]      r_q   [0:NDS];
    logic [REMW-1:0]    r_d   [0:NDS];
    logic               r_neg [0:NDS];
    logic               r_byp [0:NDS];

    logic signed [32:0] n_val;
    logic [32:0]        n_mag;

    logic [REMW-1:0]    n_rem [1:NDS];
    logic [QW-1:0]      n_low [1:NDS];
    logic [QW-1:0]      n_q   [1:NDS];

    logic [QW:0]        q_inc;
    logic signed [14:0] q_s;
    logic signed [14:0] b_s;
    logic [omw_pkg::CALW-1:0] n_blend;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_num <= ($signed({1'b0, i_factor}) - $signed(13'd2048))
                      * $signed({1'b0, i_diff});
            r1_ax  <= i_ax;
            r1_byp <= i_byp;
        end
    end

    always_comb begin
        n_val = $signed({r1_num[30], r1_num, 1'b0}) + $signed({16'b0, r1_ax});
        n_mag = n_val[32] ? 33'(-n_val) : n_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_rem[0] <= {1'b0, n_mag[28:12]};
            r_low[0] <= n_mag[11:0];
            r_q[0]   <= '0;
            r_d[0]   <= {r1_ax, 1'b0};
            r_neg[0] <= n_val[32];
            r_byp[0] <= r1_byp;
        end
    end

    for (genvar k = 1; k <= NDS; k++) begin : g_div
        always_comb begin
            logic [REMW-1:0] t;
            logic [REMW-1:0] rem;
            logic [QW-1:0]   low;
            logic [QW-1:0]   q;
            rem = r_rem[k-1];
            low = r_low[k-1];
            q   = r_q[k-1];
            for (int b = 0; b < BPS; b++) begin
                t   = {rem[REMW-2:0], low[QW-1]};
                low = {low[QW-2:0], 1'b0};
                if (t >= r_d[k-1]) begin
                    rem = t - r_d[k-1];
                    q   = {q[QW-2:0], 1'b1};
                end else begin
                    rem = t;
                    q   = {q[QW-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_low[k] = low;
            n_q[k]   = q;
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en[1+k]) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_q[k]   <= n_q[k];
                r_d[k]   <= r_d[k-1];
                r_neg[k] <= r_neg[k-1];
                r_byp[k] <= r_byp[k-1];
            end
        end
    end

    // floor division: negative quotients round away when a remainder is left
    always_comb begin
        q_inc = {1'b0, r_q[NDS]} + (QW+1)'(r_rem[NDS] != '0);
        q_s   = r_neg[NDS] ? -$signed({2'b0, q_inc}) : $signed({3'b0, r_q[NDS]});
        b_s   = $signed(15'd2048) + q_s;
        if (r_byp[NDS]) begin
            n_blend = omw_pkg::ONE_Q11;
        end else if (b_s < $signed({3'b0, omw_pkg::SC_LO})) begin
            n_blend = omw_pkg::SC_LO;
        end else if (b_s > $signed({3'b0, omw_pkg::SC_HI})) begin
            n_blend = omw_pkg::SC_HI;
        end else begin
            n_blend = b_s[omw_pkg::CALW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2+NDS]) begin
            o_blend <= n_blend;
        end
    end

endmodule

FILE: design/omw_wheel.sv
`timescale 1ns / 1ps

// One wheel: dot product, revs per metre, three calibration scales, saturation.
module omw_wheel (
    input  logic                          i_clk,
    input  omw_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [27:0]            i_vx24,
    input  logic signed [32:0]            i_vy24,
    input  logic signed [33:0]            i_w24,
    input  logic signed [15:0]            i_gx,
    input  logic signed [15:0]            i_gy,
    input  logic signed [15:0]            i_gw,
    input  logic [59:0]                   i_cal,
    input  logic [15:0]                   i_rpm,
    input  logic [16:0]                   i_diff,
    input  logic [16:0]                   i_ax,
    input  logic                          i_byp,
    input  logic                          i_vx_neg,
    output logic signed [omw_pkg::OUTW-1:0] o_speed
);

    localparam int CW = omw_pkg::CALW;
    localparam int MW = omw_pkg::MW;
    localparam int PW = omw_pkg::PW;

    logic signed [43:0]   r3_px;
    logic signed [48:0]   r3_py;
    logic signed [49:0]   r3_pw;
    logic signed [39:0]   r4_m;
    logic                 r4_pos;
    logic signed [56:0]   r5_m;
    logic                 r5_pos;
    logic signed [PW-1:0] r6_m;
    logic                 r6_pos;
    logic signed [PW-1:0] r7_m;
    logic signed [PW-1:0] r8_m;

    logic signed [52:0]   sum37;
    logic signed [57:0]   s12;
    logic signed [MW-1:0] m12;
    logic [CW-1:0]        ovr;
    logic [CW-1:0]        dir;
    logic [CW-1:0]        blend;
    logic [CW-1:0]        fsel;
    logic signed [MW-1:0] m_fin;
    logic signed [MW:0]   s8;
    logic signed [38:0]   m8;
    logic signed [omw_pkg::OUTW-1:0] n_speed;

    assign fsel = i_vx_neg ? i_cal[omw_pkg::CAL_WST*CW +: CW]
                           : i_cal[omw_pkg::CAL_EST*CW +: CW];

    omw_blend_div u_div (
        .i_clk    (i_clk),
        .i_ctl    (i_ctl),
        .i_factor (fsel),
        .i_diff   (i_diff),
        .i_ax     (i_ax),
        .i_byp    (i_byp),
        .o_blend  (blend)
    );

    assign sum37 = 53'(r3_px) + 53'(r3_py) + 53'(r3_pw) + 53'sd4096;
    assign s12   = $signed({r5_m[56], r5_m}) + 58'sd2048;
    assign m12   = s12[57:12];
    assign ovr   = omw_pkg::clamp_cal(i_cal[omw_pkg::CAL_OVR*CW +: CW],
                                      omw_pkg::OVR_LO, omw_pkg::OVR_HI);
    assign dir   = omw_pkg::clamp_cal(r6_pos ? i_cal[omw_pkg::CAL_POS*CW +: CW]
                                             : i_cal[omw_pkg::CAL_NEG*CW +: CW],
                                      omw_pkg::SC_LO, omw_pkg::SC_HI);
    assign m_fin = omw_pkg::rnd11(r8_m);
    assign s8    = $signed({m_fin[MW-1], m_fin}) + $signed((MW+1)'(128));
    assign m8    = s8[MW:8];

    always_comb begin
        if (m8 > $signed(39'sd8388607)) begin
            n_speed = 24'sh7FFFFF;
        end else if (m8 < -$signed(39'sd8388608)) begin
            n_speed = 24'sh800000;
        end else begin
            n_speed = m8[omw_pkg::OUTW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_px <= i_gx * i_vx24;
            r3_py <= i_gy * i_vy24;
            r3_pw <= i_gw * i_w24;
        end
        if (i_ctl.en[3]) begin
            r4_m   <= sum37[52:13];
            r4_pos <= (53'(r3_px) + 53'(r3_py) + 53'(r3_pw)) >= 0;
        end
        if (i_ctl.en[4]) begin
            r5_m   <= r4_m * $signed({1'b0, i_rpm});
            r5_pos <= r4_pos;
        end
        if (i_ctl.en[5]) begin
            r6_m   <= m12 * $signed({1'b0, ovr});
            r6_pos <= r5_pos;
        end
        if (i_ctl.en[6]) begin
            r7_m <= omw_pkg::rnd11(r6_m) * $signed({1'b0, dir});
        end
        if (i_ctl.en[7]) begin
            r8_m <= omw_pkg::rnd11(r7_m) * $signed({1'b0, blend});
        end
        if (i_ctl.en[8]) begin
            o_speed <= n_speed;
        end
    end

endmodule

FILE: design/omni_wheel_inverse_mixer_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                                   Item
// twist     in         s_axis_tvalid/tready/tdata[47:0]          vx, vy, yaw rate
// command   out        m_axis_tvalid/tready/tdata[119:0]         four speeds, peak
// config    in         i_cfg_valid/o_cfg_ready/index/data        one register write
//
// Ten register stages; one item a cycle sustained while the output is not stalled.
// The depth is set by the wheel chain (three products, revs per metre,
// three calibration multiplies: west and east share one, as at most one of
// them differs from 1.0); the blend divide runs alongside, 3 bits a stage.
// Synchronous active-low reset clears stage valids and loads register defaults.
// A stalled output holds; earlier stages keep filling bubbles until full.
module omni_wheel_inverse_mixer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] body_vx, [31:16] body_vy, [47:32] body_yaw_rate
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] motor_speed_0 .. [95:72] motor_speed_3, [119:96] peak_speed
    output logic [119:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [omw_pkg::IDXW-1:0] i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    localparam int W  = omw_pkg::WHEELS;
    localparam int OW = omw_pkg::OUTW;

    // configuration registers
    logic [63:0] r_geo [0:2];
    logic [59:0] r_cal [0:W-1];
    logic [63:0] r_body;

    omw_pkg::t_pipe_ctl ctl;

    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic [16:0]        ax;
    logic [16:0]        ay;
    logic [16:0]        diff;
    logic               byp;
    logic [15:0]        lat;
    logic [191:0]       geo_all;

    // stage 1
    logic signed [15:0] r1_vx;
    logic signed [15:0] r1_w;
    logic signed [32:0] r1_vyl;
    logic signed [31:0] r1_fx;
    logic signed [31:0] r1_fy;
    // stage 2
    logic signed [27:0] r2_vx24;
    logic signed [32:0] r2_vy24;
    logic signed [33:0] r2_w24;

    logic signed [OW-1:0] spd  [0:W-1];
    logic [OW-1:0]        mag  [0:W-1];
    logic [OW-1:0]        pk01;
    logic [OW-1:0]        pk23;
    logic signed [OW-1:0] r_spd [0:W-1];
    logic [OW-1:0]        r_peak;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo[0] <= omw_pkg::GEO_RST;
            r_geo[1] <= omw_pkg::GEO_RST;
            r_geo[2] <= omw_pkg::GEO_RST;
            for (int i = 0; i < W; i++) begin
                r_cal[i] <= omw_pkg::CAL_RST;
            end
            r_body <= omw_pkg::BODY_RST;
        end else if (i_cfg_valid) begin
            unique case (omw_pkg::t_reg_idx'(i_cfg_index))
                omw_pkg::REG_GEO0: r_geo[0] <= i_cfg_data;
                omw_pkg::REG_GEO1: r_geo[1] <= i_cfg_data;
                omw_pkg::REG_GEO2: r_geo[2] <= i_cfg_data;
                omw_pkg::REG_CAL0: r_cal[0] <= i_cfg_data[59:0];
                omw_pkg::REG_CAL1: r_cal[1] <= i_cfg_data[59:0];
                omw_pkg::REG_CAL2: r_cal[2] <= i_cfg_data[59:0];
                omw_pkg::REG_CAL3: r_cal[3] <= i_cfg_data[59:0];
                omw_pkg::REG_BODY: r_body   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    omw_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ctl       (ctl)
    );

    assign vx   = s_axis_tdata[15:0];
    assign vy   = s_axis_tdata[31:16];
    assign yaw  = s_axis_tdata[47:32];
    assign ax   = vx[15] ? 17'(-$signed({vx[15], vx})) : {1'b0, vx};
    assign ay   = vy[15] ? 17'(-$signed({vy[15], vy})) : {1'b0, vy};
    assign diff = ax - ay;
    // no blend when |vy| >= |vx|, which also covers vx of zero
    assign byp  = (ax <= ay);
    assign lat  = (r_body[31:16] < omw_pkg::LAT_MIN) ? omw_pkg::LAT_MIN : r_body[31:16];
    assign geo_all = {r_geo[2], r_geo[1], r_geo[0]};

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r1_vx  <= vx;
            r1_w   <= yaw;
            r1_vyl <= vy * $signed({1'b0, lat});
            r1_fx  <= $signed(r_body[47:32]) * vx;
            r1_fy  <= $signed(r_body[63:48]) * vy;
        end
        if (ctl.en[1]) begin
            r2_vx24 <= {r1_vx, 12'b0};
            r2_vy24 <= r1_vyl;
            r2_w24  <= $signed({{4{r1_w[15]}}, r1_w, 14'b0}) + 34'(r1_fx) + 34'(r1_fy);
        end
    end

    for (genvar i = 0; i < W; i++) begin : g_wheel
        omw_wheel u_wheel (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_vx24   (r2_vx24),
            .i_vy24   (r2_vy24),
            .i_w24    (r2_w24),
            .i_gx     (geo_all[16*(3*i)   +: 16]),
            .i_gy     (geo_all[16*(3*i+1) +: 16]),
            .i_gw     (geo_all[16*(3*i+2) +: 16]),
            .i_cal    (r_cal[i]),
            .i_rpm    (r_body[15:0]),
            .i_diff   (diff),
            .i_ax     (ax),
            .i_byp    (byp),
            .i_vx_neg (vx[15]),
            .o_speed  (spd[i])
        );
        // two's complement keeps the most negative code as 2^23 unsigned
        assign mag[i] = spd[i][OW-1] ? (~spd[i] + 1'b1) : spd[i];
    end

    assign pk01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    assign pk23 = (mag[3] > mag[2]) ? mag[3] : mag[2];

    always_ff @(posedge i_clk) begin
        if (ctl.en[omw_pkg::NSTG-1]) begin
            for (int i = 0; i < W; i++) begin
                r_spd[i] <= spd[i];
            end
            r_peak <= (pk23 > pk01) ? pk23 : pk01;
        end
    end

    assign m_axis_tdata = {r_peak, r_spd[3], r_spd[2], r_spd[1], r_spd[0]};

endmodule

FILE: test/omni_wheel_inverse_mixer_unit_tb.sv
`timescale 1ns / 1ps

module omni_wheel_inverse_mixer_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 3 * omw_pkg::NSTG;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] yaw;
    } t_twist;

    typedef struct packed {
        logic signed [23:0] ms0;
        logic signed [23:0] ms1;
        logic signed [23:0] ms2;
        logic signed [23:0] ms3;
        logic [23:0]        peak;
    } t_cmd;

    // directed row: twist plus an optional hand-typed expectation
    typedef struct {
        t_twist tw;
        bit     typed;
        t_cmd   cmd;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [omw_pkg::IDXW-1:0] i_cfg_index;
    logic [63:0]  i_cfg_data;

    omni_wheel_inverse_mixer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // shadow copy of the register file
    logic [63:0] mix_regs [8];

    t_cmd cmd_queue [$];
    int   n_errors;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    function automatic longint rnd_shift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint lane16(logic [63:0] w, int k);
        return longint'($signed(w[16*k +: 16]));
    endfunction

    function automatic longint cal_lane(int wheel, int f);
        return longint'(mix_regs[omw_pkg::REG_CAL0 + wheel][12*f +: 12]);
    endfunction

    // blended west/east scale, floor division with positive divisor
    function automatic longint blend_scale(longint factor, longint ax, longint ay);
        longint num;
        longint n;
        longint q;
        if (ax <= ay) begin
            return longint'(omw_pkg::ONE_Q11);
        end
        num = (factor - 2048) * (ax - ay);
        n = 2 * num + ax;
        if (n >= 0) begin
            q = n / (2 * ax);
        end else begin
            q = -((-n + 2 * ax - 1) / (2 * ax));
        end
        return 2048 + q;
    endfunction

    function automatic t_cmd mix_twist(t_twist tw);
        longint vx, vy, w, rpm, lat, ffx, ffy, ax, ay, vx24, vy24, w24;
        longint s37, ovr, dir, ws, es, m, a, peak;
        longint speeds [4];
        t_cmd c;
        vx   = tw.vx;
        vy   = tw.vy;
        w    = tw.yaw;
        rpm  = longint'(mix_regs[omw_pkg::REG_BODY][15:0]);
        lat  = longint'(mix_regs[omw_pkg::REG_BODY][31:16]);
        ffx  = lane16(mix_regs[omw_pkg::REG_BODY], 2);
        ffy  = lane16(mix_regs[omw_pkg::REG_BODY], 3);
        ax   = vx < 0 ? -vx : vx;
        ay   = vy < 0 ? -vy : vy;
        peak = 0;
        if (lat < 410) begin
            lat = 410;
        end
        vx24 = vx * 4096;
        vy24 = vy * lat;
        w24  = w * 16384 + ffx * vx + ffy * vy;
        for (int i = 0; i < 4; i++) begin
            s37 = lane16(mix_regs[(3*i) / 4], (3*i) % 4) * vx24
                + lane16(mix_regs[(3*i+1) / 4], (3*i+1) % 4) * vy24
                + lane16(mix_regs[(3*i+2) / 4], (3*i+2) % 4) * w24;
            ovr = clampl(cal_lane(i, omw_pkg::CAL_OVR), 1024, 3072);
            dir = clampl(cal_lane(i, s37 >= 0 ? omw_pkg::CAL_POS : omw_pkg::CAL_NEG),
                         1638, 2458);
            ws  = 2048;
            es  = 2048;
            if (vx < 0) begin
                ws = blend_scale(cal_lane(i, omw_pkg::CAL_WST), ax, ay);
            end
            if (vx > 0) begin
                es = blend_scale(cal_lane(i, omw_pkg::CAL_EST), ax, ay);
            end
            ws = clampl(ws, 1638, 2458);
            es = clampl(es, 1638, 2458);
            m = rnd_shift(rnd_shift(s37, 13) * rpm, 12);
            m = rnd_shift(m * ovr, 11);
            m = rnd_shift(m * dir, 11);
            m = rnd_shift(m * ws, 11);
            m = rnd_shift(m * es, 11);
            m = clampl(rnd_shift(m, 8), -8388608, 8388607);
            speeds[i] = m;
            a = m < 0 ? -m : m;
            if (a > peak) begin
                peak = a;
            end
        end
        c.ms0  = speeds[0][23:0];
        c.ms1  = speeds[1][23:0];
        c.ms2  = speeds[2][23:0];
        c.ms3  = speeds[3][23:0];
        c.peak = peak[23:0];
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // tdata packs speeds 0..3 then peak, lowest first; struct order is reversed
    function automatic t_cmd unpack_cmd(logic [119:0] d);
        t_cmd c;
        c.ms0  = d[23:0];
        c.ms1  = d[47:24];
        c.ms2  = d[71:48];
        c.ms3  = d[95:72];
        c.peak = d[119:96];
        return c;
    endfunction

    // output monitor and random backpressure
    always @(posedge i_clk) begin
        t_cmd got;
        t_cmd want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = unpack_cmd(m_axis_tdata);
                if (cmd_queue.size() == 0) begin
                    report_mismatch("unexpected command", 0, 0);
                end else begin
                    want = cmd_queue.pop_front();
                    if (got.ms0 !== want.ms0) report_mismatch("motor_speed_0", got.ms0, want.ms0);
                    if (got.ms1 !== want.ms1) report_mismatch("motor_speed_1", got.ms1, want.ms1);
                    if (got.ms2 !== want.ms2) report_mismatch("motor_speed_2", got.ms2, want.ms2);
                    if (got.ms3 !== want.ms3) report_mismatch("motor_speed_3", got.ms3, want.ms3);
                    if (got.peak !== want.peak) report_mismatch("peak_speed", got.peak, want.peak);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // valid drops for one cycle after each write
    task automatic write_reg(omw_pkg::t_reg_idx idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mix_regs[idx] = (idx >= omw_pkg::REG_CAL0 && idx <= omw_pkg::REG_CAL3)
                        ? {4'd0, val[59:0]} : val;
        @(posedge i_clk);
    endtask

    // send one twist; the expectation is queued at the accepting edge
    task automatic send_twist(t_twist tw, bit typed, t_cmd typed_cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tw.yaw, tw.vy, tw.vx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cmd_queue.push_back(typed ? typed_cmd : mix_twist(tw));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_field();
        unique case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] rnd_factor();
        unique case ($urandom_range(4))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom_range(3200, 900));
        endcase
    endfunction

    task automatic random_config(bit extreme);
        logic [59:0] cal;
        for (int k = 0; k < 3; k++) begin
            write_reg(omw_pkg::t_reg_idx'(omw_pkg::REG_GEO0 + k),
                      extreme ? 64'h8000_7FFF_8000_7FFF : {$urandom, $urandom});
        end
        for (int k = 0; k < 4; k++) begin
            for (int f = 0; f < 5; f++) cal[12*f +: 12] = extreme ? 12'hFFF : rnd_factor();
            write_reg(omw_pkg::t_reg_idx'(omw_pkg::REG_CAL0 + k), {4'd0, cal});
        end
        if (extreme) begin
            write_reg(omw_pkg::REG_BODY, 64'h7FFF_8000_FFFF_FFFF);
        end else begin
            write_reg(omw_pkg::REG_BODY, {16'($urandom), 16'($urandom),
                                 16'($urandom_range(1000)), 16'($urandom_range(1200))});
        end
    endtask

    task automatic random_phase(int n_items);
        t_twist tw;
        t_cmd   none;
        none = '0;
        for (int n = 0; n < n_items; n++) begin
            tw.vx  = rnd_field();
            tw.vy  = rnd_field();
            tw.yaw = rnd_field();
            send_twist(tw, 1'b0, none);
        end
        drain();
    endtask

    t_row rows [$];

    initial begin
        t_row r;
        n_errors       = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = omw_pkg::REG_GEO0;
        i_cfg_data     = '0;
        mix_regs = '{omw_pkg::GEO_RST, omw_pkg::GEO_RST, omw_pkg::GEO_RST,
                     {4'd0, omw_pkg::CAL_RST}, {4'd0, omw_pkg::CAL_RST},
                     {4'd0, omw_pkg::CAL_RST}, {4'd0, omw_pkg::CAL_RST},
                     omw_pkg::BODY_RST};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset revs per metre is zero: every command is zero
        r.typed = 1'b1;
        r.cmd   = '0;
        r.tw = '{16'h7FFF, 16'h8000, 16'h7FFF}; rows.push_back(r);
        r.tw = '{16'h8000, 16'h7FFF, 16'h8000}; rows.push_back(r);
        foreach (rows[i]) send_twist(rows[i].tw, rows[i].typed, rows[i].cmd);
        drain();

        // identity-like geometry, unit revs per metre, unit factors
        write_reg(omw_pkg::REG_GEO0, {16'h2000, 16'h0000, 16'h0000, 16'h2000});
        write_reg(omw_pkg::REG_GEO1, {16'h0000, 16'h2000, 16'h0000, 16'h2000});
        write_reg(omw_pkg::REG_GEO2, {16'hE000, 16'h2000, 16'hE000, 16'h2000});
        write_reg(omw_pkg::REG_BODY, {16'd0, 16'd0, 16'd0, 16'd256});   // lateral floor
        rows.delete();
        r.typed = 1'b0;
        // zero vx, vy dominating, vx dominating, both signs, extremes
        r.tw = '{16'h0000, 16'h0000, 16'h0000}; rows.push_back(r);
        r.tw = '{16'h0000, 16'h1000, 16'h0400}; rows.push_back(r);
        r.tw = '{16'h1000, 16'h0800, 16'h0000}; rows.push_back(r);
        r.tw = '{16'hF000, 16'h0800, 16'hFC00}; rows.push_back(r);
        r.tw = '{16'h0800, 16'hF000, 16'h0000}; rows.push_back(r);
        r.tw = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; rows.push_back(r);
        r.tw = '{16'h8000, 16'h8000, 16'h8000}; rows.push_back(r);
        r.tw = '{16'h8000, 16'h0001, 16'h7FFF}; rows.push_back(r);
        foreach (rows[i]) send_twist(rows[i].tw, rows[i].typed, rows[i].cmd);
        drain();

        // extreme configuration: saturating outputs, clamped factors
        random_config(1'b1);
        foreach (rows[i]) send_twist(rows[i].tw, rows[i].typed, rows[i].cmd);
        drain();

        // random phases across idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            unique case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            random_config(1'b0);
            random_phase(62);
        end

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/omw_pkg.sv
design/omw_pipe_ctrl.sv
design/omw_blend_div.sv
design/omw_wheel.sv
design/omni_wheel_inverse_mixer_unit.sv
test/omni_wheel_inverse_mixer_unit_tb.sv
